@@ hdl/longest_unique_run_tracker_top_defines.svh @@
// assertion macros shared by the run tracker modules
`ifndef LONGEST_UNIQUE_RUN_TRACKER_TOP_DEFINES_SVH
`define LONGEST_UNIQUE_RUN_TRACKER_TOP_DEFINES_SVH

// condition in this cycle forces a check in the next one
`define LURT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// condition and check in the same cycle
`define LURT_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

@@ hdl/lurt_pkg.sv @@
// shared constants and the item record carried along the cell chain
package lurt_pkg;

  localparam int CODE_W            = 7;
  localparam int CODE_RANGE        = 2 ** CODE_W;
  localparam int POS_W             = 16;
  localparam int ALPHABET_SIZE_DEF = 128;
  localparam int S_DATA_W          = 8;
  localparam int M_DATA_W          = 16;

  localparam longint unsigned MAX_LEN   = 64'd65535;
  localparam longint unsigned POS_LIMIT = (64'd1 << POS_W) - 64'd1;
  localparam logic [POS_W-1:0] LEN_CAP  =
    POS_W'((MAX_LEN < POS_LIMIT) ? MAX_LEN : POS_LIMIT);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eos;
    logic [POS_W-1:0]  pos;
    logic              skip;
    logic              too_long;
    logic [POS_W-1:0]  seen;
  } item_t;

endpackage

@@ hdl/lurt_cell.sv @@
// one table entry of the chain: looks up and updates the entry as an item passes
`include "longest_unique_run_tracker_top_defines.svh"

module lurt_cell #(
  parameter int IDX   = 0,
  parameter int ALPHA = lurt_pkg::ALPHABET_SIZE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  lurt_pkg::item_t in_item,
  output logic            out_valid,
  output lurt_pkg::item_t out_item
);

  // codes that fold onto this entry
  localparam int NUM_ALIAS = (lurt_pkg::CODE_RANGE - 1 - IDX) / ALPHA + 1;

  logic [lurt_pkg::POS_W-1:0] entry;
  logic                       match;

  always_comb begin
    match = 1'b0;
    for (int k = 0; k < NUM_ALIAS; k++) begin
      if (in_item.code == lurt_pkg::CODE_W'(IDX + k * ALPHA)) begin
        match = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        // end of string empties every entry behind the last item
        if (in_item.eos) begin
          entry <= '0;
        end else if (match && !in_item.skip) begin
          entry <= in_item.pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= in_item;
      if (match) begin
        out_item.seen <= entry;
      end
    end
  end

  `LURT_ASSERT_NEXT(a_cell_clear, adv && in_valid && in_item.eos, entry == '0, "entry not cleared at end of string")
  `LURT_ASSERT_NEXT(a_cell_write, adv && in_valid && !in_item.eos && !in_item.skip && match, entry == $past(in_item.pos) + 1'b1, "entry not written with position plus one")
  `LURT_ASSERT_NEXT(a_cell_hold, !adv, $stable(entry), "entry changed while chain stalled")

endmodule

@@ hdl/lurt_tail.sv @@
// window start and best length update, with the output register
`include "longest_unique_run_tracker_top_defines.svh"

module lurt_tail (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  lurt_pkg::item_t               in_item,
  input  logic                          m_ready,
  output logic                          adv,
  output logic                          m_valid,
  output logic [lurt_pkg::POS_W-1:0]    result,
  output logic                          done,
  output logic                          too_long
);

  logic [lurt_pkg::POS_W-1:0] window_start;
  logic [lurt_pkg::POS_W-1:0] best;
  logic [lurt_pkg::POS_W-1:0] start_max;
  logic [lurt_pkg::POS_W-1:0] run_len;
  logic [lurt_pkg::POS_W-1:0] best_next;
  logic                       out_load;
  logic                       upd;

  assign out_load = !m_valid || m_ready;
  // an empty last cell lets the chain move even while a result waits
  assign adv      = out_load || !in_valid;
  assign upd      = in_valid && out_load;

  always_comb begin
    start_max = (in_item.seen > window_start) ? in_item.seen : window_start;
    run_len   = in_item.pos - start_max + 1'b1;
    if (in_item.skip) begin
      best_next = best;
    end else begin
      best_next = (run_len > best) ? run_len : best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      best         <= '0;
      m_valid      <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid <= in_valid;
      end
      if (upd) begin
        if (in_item.eos) begin
          window_start <= '0;
          best         <= '0;
        end else if (!in_item.skip) begin
          window_start <= start_max;
          best         <= best_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      result   <= best_next;
      done     <= in_item.eos;
      too_long <= in_item.too_long;
    end
  end

  `LURT_ASSERT_NEXT(a_best_mono, upd && !in_item.eos, best >= $past(best), "best length fell within a string")
  `LURT_ASSERT_NEXT(a_start_bound, upd && !in_item.eos && !in_item.skip, window_start <= $past(in_item.pos), "window start passed the position")
  `LURT_ASSERT_NEXT(a_result_nonzero, upd && !in_item.skip, result != '0, "zero length after a counted item")

endmodule

@@ hdl/longest_unique_run_tracker_top.sv @@
// Longest repeat-free run tracker: one 7-bit character per item, one result per item
// giving the longest run without a repeated character in the string so far. The
// table lives in a chain of cells, one entry per character code modulo ALPHABET_SIZE
// (min of ALPHABET_SIZE and 128 cells); unless stalled, an item walks the chain one cell
// per cycle, picking up the last-seen position of its code and leaving its own, so a new
// item is taken every cycle; each result is held in the output register after its item
// leaves the last cell. The chain stalls only while the output register holds an untaken
// result and the last cell holds an item. The item marked tlast clears each entry as it
// passes, so the next string may follow in the very next cycle; no clearing pass is needed.
module longest_unique_run_tracker_top #(
  parameter int ALPHABET_SIZE = lurt_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lurt_pkg::S_DATA_W-1:0] s_tdata,   // [6:0] char_code, [7] zero
  input  logic                          s_tlast,   // end_of_string
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lurt_pkg::M_DATA_W-1:0] m_tdata,   // [15:0] longest_so_far
  output logic                          m_tlast,   // string_done
  output logic                          m_tuser    // [0] too_long
);

  localparam int NUM_CELLS = (ALPHABET_SIZE < lurt_pkg::CODE_RANGE) ?
                             ALPHABET_SIZE : lurt_pkg::CODE_RANGE;

  logic                       chain_valid [NUM_CELLS+1];
  lurt_pkg::item_t            chain_item  [NUM_CELLS+1];
  logic                       adv;
  logic                       accept;
  logic                       skip;
  logic                       overflow_seen;
  logic [lurt_pkg::POS_W-1:0] position;

  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;
  // past the length limit an item only flags the overflow
  assign skip     = (position >= lurt_pkg::LEN_CAP);

  always_comb begin
    chain_valid[0]         = s_tvalid;
    chain_item[0].code     = s_tdata[lurt_pkg::CODE_W-1:0];
    chain_item[0].eos      = s_tlast;
    chain_item[0].pos      = position;
    chain_item[0].skip     = skip;
    chain_item[0].too_long = overflow_seen || skip;
    chain_item[0].seen     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        position      <= '0;
        overflow_seen <= 1'b0;
      end else if (skip) begin
        overflow_seen <= 1'b1;
      end else begin
        position <= position + 1'b1;
      end
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    lurt_cell #(
      .IDX   (i),
      .ALPHA (ALPHABET_SIZE)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (chain_valid[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  lurt_tail u_tail (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[NUM_CELLS]),
    .in_item  (chain_item[NUM_CELLS]),
    .m_ready  (m_tready),
    .adv      (adv),
    .m_valid  (m_tvalid),
    .result   (m_tdata),
    .done     (m_tlast),
    .too_long (m_tuser)
  );

endmodule

@@ sim/longest_unique_run_tracker_top_tb.sv @@
// self-checking testbench for the longest repeat-free run tracker
module longest_unique_run_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAIN_LATENCY = lurt_pkg::ALPHABET_SIZE_DEF + 1;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_ITEMS  = 1250;

  typedef struct {
    bit [lurt_pkg::POS_W-1:0] longest;
    bit                       done;
    bit                       too_long;
  } run_result_t;

  // tracks the window over the current string and queues the result of every character
  class unique_run_predictor;
    bit [lurt_pkg::POS_W-1:0] last_seen [lurt_pkg::CODE_RANGE];
    bit [lurt_pkg::POS_W-1:0] window_start;
    bit [lurt_pkg::POS_W-1:0] position;
    bit [lurt_pkg::POS_W-1:0] best;
    bit                       overflow;
    run_result_t              expected_runs [$];
    int                       mismatch_count;

    function void clear_string();
      foreach (last_seen[i]) last_seen[i] = '0;
      window_start = '0;
      position     = '0;
      best         = '0;
      overflow     = 1'b0;
    endfunction

    function void note_char(bit [lurt_pkg::CODE_W-1:0] code, bit eos);
      run_result_t              r;
      bit [lurt_pkg::POS_W-1:0] start;
      bit [lurt_pkg::POS_W:0]   span;
      if (position >= lurt_pkg::LEN_CAP) begin
        overflow = 1'b1;
      end else begin
        start = window_start;
        // the alphabet covers every 7-bit code, so the code is the slot
        if (last_seen[code] > start) start = last_seen[code];
        span = {1'b0, position} - {1'b0, start} + 1'b1;
        if (span > {1'b0, best}) best = span[lurt_pkg::POS_W-1:0];
        window_start    = start;
        last_seen[code] = position + 1'b1;
        position        = position + 1'b1;
      end
      r.longest  = best;
      r.done     = eos;
      r.too_long = overflow;
      expected_runs.insert(expected_runs.size(), r);
      if (eos) clear_string();
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
    endtask

    task check_result(bit [lurt_pkg::POS_W-1:0] longest, bit done, bit too_long);
      run_result_t r;
      if (expected_runs.size() == 0) begin
        report("unexpected result, longest_so_far", 32'(longest), 0);
      end else begin
        r = expected_runs.pop_front();
        if (longest !== r.longest) report("longest_so_far", 32'(longest), 32'(r.longest));
        if (done !== r.done) report("string_done", 32'(done), 32'(r.done));
        if (too_long !== r.too_long) report("too_long", 32'(too_long), 32'(r.too_long));
      end
    endtask

    function int pending();
      return expected_runs.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [lurt_pkg::S_DATA_W-1:0] s_tdata;
  logic                          s_tlast;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [lurt_pkg::M_DATA_W-1:0] m_tdata;
  logic                          m_tlast;
  logic                          m_tuser;

  unique_run_predictor runs = new();
  bit                  idle_on;
  int                  stall_left;
  int                  cycle_count;
  int                  chars_sent;

  longest_unique_run_tracker_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) runs.check_result(m_tdata, m_tlast, m_tuser);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays high between back-to-back items; it only drops for a gap
  task send_char(bit [lurt_pkg::CODE_W-1:0] code, bit eos);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, code};
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    runs.note_char(code, eos);
    chars_sent++;
  endtask

  // full range, a narrow band that repeats often, or a shuffled run of every code
  task send_string(int len, int mode);
    bit [lurt_pkg::CODE_W-1:0] perm [lurt_pkg::CODE_RANGE];
    bit [lurt_pkg::CODE_W-1:0] tmp;
    bit [lurt_pkg::CODE_W-1:0] code;
    int                        base;
    int                        band;
    int                        j;
    base = $urandom_range(0, lurt_pkg::CODE_RANGE - 1);
    band = $urandom_range(1, 15);
    foreach (perm[i]) perm[i] = lurt_pkg::CODE_W'(i);
    for (int i = lurt_pkg::CODE_RANGE - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < len; i++) begin
      case (mode)
        0:       code = lurt_pkg::CODE_W'($urandom_range(0, lurt_pkg::CODE_RANGE - 1));
        1:       code = lurt_pkg::CODE_W'(base + $urandom_range(0, band));
        default: code = perm[i % lurt_pkg::CODE_RANGE];
      endcase
      send_char(code, i == len - 1);
    end
  endtask

  initial begin
    int unsigned dir_code [24] = '{0, 127, 97, 98, 99, 97, 98, 99, 98, 98, 5, 5, 5,
                                   0, 127, 0, 127, 1, 10, 20, 30, 20, 10, 40};
    bit          dir_last [24] = '{1, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1,
                                   0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1};
    int          len;
    int          r;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    m_tready   = 1'b0;
    clk        = 1'b0;
    idle_on    = 1'b1;
    stall_left = 0;
    runs.clear_string();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-character strings at both code extremes, repeats, back-to-back strings
    for (int i = 0; i < 24; i++) send_char(lurt_pkg::CODE_W'(dir_code[i]), dir_last[i]);

    chars_sent = 0;
    while (chars_sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      if (r < 65)      len = $urandom_range(1, 12);
      else if (r < 92) len = $urandom_range(13, 60);
      else             len = $urandom_range(100, 300);
      r = $urandom_range(0, 9);
      send_string(len, (r < 4) ? 0 : (r < 8) ? 1 : 2);
    end

    // a short string at the end to see everything cleared
    idle_on = 1'b1;
    send_string(5, 1);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (runs.pending() != 0) @(posedge clk);
    repeat (CHAIN_LATENCY + 20) @(posedge clk);
    if (runs.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ longest_unique_run_tracker_top.f @@
+incdir+hdl
hdl/lurt_pkg.sv
hdl/lurt_cell.sv
hdl/lurt_tail.sv
hdl/longest_unique_run_tracker_top.sv
sim/longest_unique_run_tracker_top_tb.sv
